[hdl/dpasr_pkg.sv]
package dpasr_pkg;

  localparam int CMD_W    = 2;
  localparam int OBJ_ID_W = 10;
  localparam int STATUS_W = 3;
  localparam int SLOT_W_P = 8;
  localparam int COUNT_W_P = 9;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd4;

  // Declared top field first, so status lands in the lowest bits.
  typedef struct packed {
    logic [COUNT_W_P-1:0] active_count;
    logic [OBJ_ID_W-1:0]  moved_id;
    logic [SLOT_W_P-1:0]  move_source;
    logic                 moved;
    logic [SLOT_W_P-1:0]  slot;
    logic [STATUS_W-1:0]  status;
  } result_t;

endpackage

[hdl/dense_pool_allocator_swap_remove.sv]
// Dense pool allocator with swap-remove. Active entries always occupy slots 0 to count-1.
// Create hands out slot "count", destroy frees the id's slot and moves the last active
// entry into it (moved, move_source and moved_id tell an outside memory what to copy),
// lookup returns the id's slot. Each command gives exactly one result beat carrying a
// status and the active count. On accept a command issues the registered reads of the
// id-to-slot, presence and slot-to-id memories; the execute state then decides and writes
// back, and waits there only while the previous result beat has not been taken. The next
// command is taken while a result still waits. After reset the presence memory is swept
// clear, one id per cycle, so in_tready stays low until every id has been cleared.
module dense_pool_allocator_swap_remove #(
  parameter int POOL_SLOTS = 256,
  parameter int ID_SPACE   = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [1:0] command, [11:2] object_id, [15:12] zero
  input  logic [dpasr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] status, [10:3] slot, [11] moved, [19:12] move_source,
  // [29:20] moved_id, [38:30] active_count, [39] zero
  output logic [dpasr_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import dpasr_pkg::*;

  localparam int SLOT_W = $clog2(POOL_SLOTS);
  localparam int ID_W   = $clog2(ID_SPACE);
  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
  localparam logic [31:0] ID_LIMIT = 32'(ID_SPACE);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [ID_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [OBJ_ID_W-1:0] id_r;
  logic                in_space_r;
  result_t             res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                present_mem [ID_SPACE];
  logic [SLOT_W-1:0]   sid_mem [ID_SPACE];
  logic [ID_W-1:0]     ids_mem [POOL_SLOTS];
  logic                present_q;
  logic [SLOT_W-1:0]   sid_q;
  logic [ID_W-1:0]     ids_q;

  logic                pres_we, sid_we, ids_we;
  logic [ID_W-1:0]     pres_wa, sid_wa;
  logic                pres_wd;
  logic [SLOT_W-1:0]   sid_wd, ids_wa;
  logic [ID_W-1:0]     ids_wd;

  logic                accept, do_exec;
  logic [CMD_W-1:0]    in_cmd;
  logic [OBJ_ID_W-1:0] in_id;
  logic                present, full, empty, swap;
  logic [SLOT_W-1:0]   cnt_slot, last_slot;

  assign in_cmd    = in_tdata[CMD_W-1:0];
  assign in_id     = in_tdata[CMD_W+OBJ_ID_W-1:CMD_W];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign do_exec   = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

  assign present   = in_space_r && present_q;
  assign full      = (count_r >= CNT_W'(POOL_SLOTS));
  assign empty     = (count_r == '0);
  assign cnt_slot  = SLOT_W'(count_r);
  assign last_slot = SLOT_W'(count_r - CNT_W'(1));
  assign swap      = (sid_q != last_slot);

  // Memories: one write and one registered read each; reads issue on accept.
  always_ff @(posedge clk) begin
    if (pres_we) begin
      present_mem[pres_wa] <= pres_wd;
    end
    if (accept) begin
      present_q <= present_mem[ID_W'(in_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (sid_we) begin
      sid_mem[sid_wa] <= sid_wd;
    end
    if (accept) begin
      sid_q <= sid_mem[ID_W'(in_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (ids_we) begin
      ids_mem[ids_wa] <= ids_wd;
    end
    if (accept) begin
      ids_q <= ids_mem[last_slot];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    pres_we = 1'b0;
    pres_wa = ID_W'(id_r);
    pres_wd = 1'b0;
    sid_we  = 1'b0;
    sid_wa  = ID_W'(id_r);
    sid_wd  = cnt_slot;
    ids_we  = 1'b0;
    ids_wa  = cnt_slot;
    ids_wd  = ID_W'(id_r);

    case (state_r)
      S_CLEAR: begin
        pres_we      = 1'b1;
        pres_wa      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ID_W'(1);
        if (clr_addr_r == ID_W'(ID_SPACE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (do_exec) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          case (cmd_r)
            CMD_CREATE: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else if (!in_space_r) begin
                res_nxt.status = ST_ABSENT;
              end else if (present) begin
                res_nxt.status = ST_DUP;
              end else begin
                res_nxt.status = ST_OK;
                res_nxt.slot   = SLOT_W_P'(cnt_slot);
                pres_we   = 1'b1;
                pres_wd   = 1'b1;
                sid_we    = 1'b1;
                ids_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DESTROY: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else if (!present) begin
                res_nxt.status = ST_ABSENT;
              end else begin
                res_nxt.status = ST_OK;
                res_nxt.slot   = SLOT_W_P'(sid_q);
                pres_we   = 1'b1;
                count_nxt = count_r - CNT_W'(1);
                // Move the last entry into the freed slot.
                if (swap) begin
                  res_nxt.moved       = 1'b1;
                  res_nxt.move_source = SLOT_W_P'(last_slot);
                  res_nxt.moved_id    = OBJ_ID_W'(ids_q);
                  sid_we = 1'b1;
                  sid_wa = ids_q;
                  sid_wd = sid_q;
                  ids_we = 1'b1;
                  ids_wa = sid_q;
                  ids_wd = ids_q;
                end
              end
            end
            default: begin
              if (!present) begin
                res_nxt.status = ST_ABSENT;
              end else begin
                res_nxt.status = ST_OK;
                res_nxt.slot   = SLOT_W_P'(sid_q);
              end
            end
          endcase
          res_nxt.active_count = COUNT_W_P'(count_nxt);
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      cmd_r      <= in_cmd;
      id_r       <= in_id;
      in_space_r <= ({22'd0, in_id} < ID_LIMIT);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(POOL_SLOTS))
    else $error("active count beyond pool size");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result loaded outside execute");

  a_create_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_exec && cmd_r == CMD_CREATE && res_nxt.status == ST_OK)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("create did not advance count");

  a_destroy_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (do_exec && cmd_r == CMD_DESTROY && res_nxt.status == ST_OK)
      |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("destroy did not retire count");

endmodule

[sim/tb_dense_pool_allocator_swap_remove.sv]
module tb_dense_pool_allocator_swap_remove;
  timeunit 1ns;
  timeprecision 1ps;

  import dpasr_pkg::*;

  localparam int POOL_SLOTS  = 256;
  localparam int ID_SPACE    = 1024;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_MIX  = 50;
  localparam int DRAIN_STEPS = 40;

  // command 3 is unused by the block and behaves as a lookup
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [OBJ_ID_W-1:0] id;
    bit                  typed_in;
    result_t             want;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // mirror of the pool contents
  logic [SLOT_W_P-1:0]  slot_by_id [ID_SPACE];
  bit                   id_live    [ID_SPACE];
  logic [OBJ_ID_W-1:0]  id_by_slot [POOL_SLOTS];
  logic [COUNT_W_P-1:0] live_count = '0;
  int                   peak_count = 0;

  result_t     pending_results[$];
  script_row_t script[$];

  int mismatch_count = 0;
  int commands_sent  = 0;
  int results_seen   = 0;
  int status_tally[8];
  int burst_left     = 0;
  bit offering       = 1'b0;
  bit hold_req       = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dense_pool_allocator_swap_remove #(
    .POOL_SLOTS(POOL_SLOTS),
    .ID_SPACE  (ID_SPACE)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic result_t mk_result(logic [STATUS_W-1:0] st, int slot, bit mv, int src,
                                        int mid, int cnt);
    result_t r;
    r = '0;
    r.status       = st;
    r.slot         = SLOT_W_P'(slot);
    r.moved        = mv;
    r.move_source  = SLOT_W_P'(src);
    r.moved_id     = OBJ_ID_W'(mid);
    r.active_count = COUNT_W_P'(cnt);
    return r;
  endfunction

  // Update the mirror with one command and return the beat it must produce.
  function automatic result_t apply_command(logic [CMD_W-1:0] cmd, logic [OBJ_ID_W-1:0] id);
    result_t             r;
    bit                  present;
    int                  s;
    int                  last;
    logic [OBJ_ID_W-1:0] mid;
    present = (int'(id) < ID_SPACE) && id_live[id];
    r = mk_result(ST_OK, 0, 0, 0, 0, 0);
    if (cmd == CMD_CREATE) begin
      if (int'(live_count) >= POOL_SLOTS) begin
        r.status = ST_FULL;
      end else if (int'(id) >= ID_SPACE) begin
        r.status = ST_ABSENT;
      end else if (present) begin
        r.status = ST_DUP;
      end else begin
        s = int'(live_count);
        slot_by_id[id] = SLOT_W_P'(s);
        id_live[id]    = 1'b1;
        id_by_slot[s]  = id;
        live_count     = live_count + 1'b1;
        r.slot         = SLOT_W_P'(s);
      end
    end else if (cmd == CMD_DESTROY) begin
      if (live_count == 0) begin
        r.status = ST_EMPTY;
      end else if (!present) begin
        r.status = ST_ABSENT;
      end else begin
        s    = int'(slot_by_id[id]);
        last = int'(live_count) - 1;
        id_live[id] = 1'b0;
        live_count  = COUNT_W_P'(last);
        r.slot      = SLOT_W_P'(s);
        // swap the last active entry into the hole
        if (s != last) begin
          mid = id_by_slot[last];
          slot_by_id[mid] = SLOT_W_P'(s);
          id_by_slot[s]   = mid;
          r.moved         = 1'b1;
          r.move_source   = SLOT_W_P'(last);
          r.moved_id      = mid;
        end
      end
    end else if (!present) begin
      r.status = ST_ABSENT;
    end else begin
      r.slot = slot_by_id[id];
    end
    r.active_count = live_count;
    if (int'(live_count) > peak_count) peak_count = int'(live_count);
    return r;
  endfunction

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [OBJ_ID_W-1:0] id, bit typed_in,
                              result_t want);
    result_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - OBJ_ID_W - CMD_W){1'b0}}, id, cmd};
    offering  = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_command(cmd, id);
    pending_results.push_back(typed_in ? want : predicted);
    commands_sent++;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      offering  = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic idle_until_drained();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering  = 1'b0;
    end
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [OBJ_ID_W-1:0] any_live_id();
    return id_by_slot[$urandom_range(0, int'(live_count) - 1)];
  endfunction

  // pick a random id that is not live yet
  function automatic logic [OBJ_ID_W-1:0] fresh_id();
    logic [OBJ_ID_W-1:0] id;
    id = OBJ_ID_W'($urandom);
    while (id_live[id]) id = id + 1'b1;
    return id;
  endfunction

  task automatic random_command();
    int                  pick;
    logic [CMD_W-1:0]    cmd;
    logic [OBJ_ID_W-1:0] id;
    pick = $urandom_range(0, 99);
    id   = OBJ_ID_W'($urandom);
    if (pick < 40) begin
      cmd = CMD_CREATE;
      if (live_count != 0 && $urandom_range(0, 9) < 2) id = any_live_id();
    end else if (pick < 75) begin
      cmd = CMD_DESTROY;
      if (live_count != 0 && $urandom_range(0, 9) < 8) id = any_live_id();
    end else begin
      cmd = ($urandom_range(0, 4) == 0) ? CMD_SPARE : CMD_LOOKUP;
      if (live_count != 0 && $urandom_range(0, 9) < 8) id = any_live_id();
    end
    send_command(cmd, id, 1'b0, '0);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(result_t)-1:0];
      results_seen++;
      status_tally[got.status]++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("slot", want.slot, got.slot);
        check_field("moved", want.moved, got.moved);
        check_field("move_source", want.move_source, got.move_source);
        check_field("moved_id", want.moved_id, got.moved_id);
        check_field("active_count", want.active_count, got.active_count);
      end
    end
  end

  // Output back-pressure: alternating stretches of free flow, random stalls and a
  // fixed pattern, plus one long hold-off on request.
  initial begin : result_sink
    int mode;
    int span;
    int k;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(8, 40);
        for (k = 0; k < span; k++) begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= ($urandom_range(0, 99) < 60);
            default: out_tready <= (k % 3 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    foreach (id_live[j]) id_live[j] = 1'b0;

    script.push_back('{CMD_DESTROY, 10'd0,    1'b1, mk_result(ST_EMPTY,  0, 0, 0, 0, 0)});
    script.push_back('{CMD_LOOKUP,  10'd1023, 1'b1, mk_result(ST_ABSENT, 0, 0, 0, 0, 0)});
    script.push_back('{CMD_CREATE,  10'd0,    1'b1, mk_result(ST_OK,     0, 0, 0, 0, 1)});
    script.push_back('{CMD_CREATE,  10'd1023, 1'b1, mk_result(ST_OK,     1, 0, 0, 0, 2)});
    script.push_back('{CMD_CREATE,  10'd0,    1'b1, mk_result(ST_DUP,    0, 0, 0, 0, 2)});
    script.push_back('{CMD_CREATE,  10'h2AA,  1'b0, '0});
    script.push_back('{CMD_CREATE,  10'h155,  1'b0, '0});
    script.push_back('{CMD_LOOKUP,  10'd1023, 1'b0, '0});
    script.push_back('{CMD_SPARE,   10'h2AA,  1'b0, '0});
    script.push_back('{CMD_DESTROY, 10'd0,    1'b0, '0});
    script.push_back('{CMD_LOOKUP,  10'h155,  1'b0, '0});
    script.push_back('{CMD_DESTROY, 10'd5,    1'b1, mk_result(ST_ABSENT, 0, 0, 0, 0, 3)});
    script.push_back('{CMD_LOOKUP,  10'd0,    1'b1, mk_result(ST_ABSENT, 0, 0, 0, 0, 3)});
    script.push_back('{CMD_DESTROY, 10'h155,  1'b0, '0});
    script.push_back('{CMD_DESTROY, 10'h2AA,  1'b0, '0});
    script.push_back('{CMD_DESTROY, 10'd1023, 1'b0, '0});
    script.push_back('{CMD_DESTROY, 10'd1023, 1'b1, mk_result(ST_EMPTY,  0, 0, 0, 0, 0)});
    script.push_back('{CMD_SPARE,   10'd1023, 1'b1, mk_result(ST_ABSENT, 0, 0, 0, 0, 0)});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) send_command(script[r].cmd, script[r].id, script[r].typed_in,
                                     script[r].want);

    for (i = 0; i < RANDOM_MIX; i++) begin
      if (i == 10) hold_req = 1'b1;
      random_command();
    end

    idle_until_drained();

    // fill to capacity, then push past it
    while (int'(live_count) < POOL_SLOTS) send_command(CMD_CREATE, fresh_id(), 1'b0, '0);
    send_command(CMD_CREATE, OBJ_ID_W'($urandom), 1'b0, '0);
    send_command(CMD_CREATE, any_live_id(), 1'b0, '0);
    send_command(CMD_CREATE, OBJ_ID_W'($urandom), 1'b0, '0);
    for (i = 0; i < 6; i++) send_command(CMD_LOOKUP, any_live_id(), 1'b0, '0);

    // retire a share of the pool, one random victim at a time
    for (i = 0; i < DRAIN_STEPS && live_count != 0; i++) begin
      send_command(CMD_DESTROY, any_live_id(), 1'b0, '0);
    end
    send_command(CMD_DESTROY, OBJ_ID_W'($urandom), 1'b0, '0);

    for (i = 0; i < RANDOM_MIX; i++) random_command();

    idle_until_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d commands, %0d results: ok %0d, full %0d, empty %0d, absent %0d, dup %0d",
             commands_sent, results_seen, status_tally[ST_OK], status_tally[ST_FULL],
             status_tally[ST_EMPTY], status_tally[ST_ABSENT], status_tally[ST_DUP]);
    $display("peak occupancy %0d of %0d slots, one output hold-off of %0d cycles",
             peak_count, POOL_SLOTS, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
